// ===== rtl/core/aes_rr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes_rr_pkg
// shared constants, types and round functions for the reduced-round cipher
// ---------------------------------------------------------------------------
package aes_rr_pkg;

  localparam int Rounds = 10;

  localparam logic [3:0] RegKeyHigh  = 4'd0;
  localparam logic [3:0] RegKeyLow   = 4'd1;
  localparam logic [3:0] RegRounds   = 4'd2;
  localparam logic [3:0] RegLastMix  = 4'd3;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  // per-word settings travelling down the pipe
  typedef struct packed {
    logic [3:0] nrounds;
    logic       last_mix;
  } ctl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] RCON [Rounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
  };

  // byte i of the state sits at bits 127-8i
  function automatic byte_t get_b(blk_t s, int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic byte_t gmul2(byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic blk_t key_step(blk_t k, int idx);
    byte_t kb [16];
    blk_t  r;
    kb[0] = get_b(k, 0) ^ SBOX[get_b(k, 13)] ^ RCON[idx];
    kb[1] = get_b(k, 1) ^ SBOX[get_b(k, 14)];
    kb[2] = get_b(k, 2) ^ SBOX[get_b(k, 15)];
    kb[3] = get_b(k, 3) ^ SBOX[get_b(k, 12)];
    for (int w = 4; w < 16; w++) begin
      kb[w] = get_b(k, w) ^ kb[w-4];
    end
    for (int w = 0; w < 16; w++) begin
      r[127-8*w -: 8] = kb[w];
    end
    return r;
  endfunction

  function automatic blk_t sub_shift_mix(blk_t s, logic mix);
    byte_t t [16];
    byte_t a0, a1, a2, a3, al;
    blk_t  r;
    for (int c = 0; c < 4; c++) begin
      for (int rr = 0; rr < 4; rr++) begin
        t[4*c+rr] = SBOX[get_b(s, 4*((c+rr)%4)+rr)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[127-32*c -: 8]  = mix ? (a0 ^ al ^ gmul2(a0 ^ a1)) : a0;
      r[119-32*c -: 8]  = mix ? (a1 ^ al ^ gmul2(a1 ^ a2)) : a1;
      r[111-32*c -: 8]  = mix ? (a2 ^ al ^ gmul2(a2 ^ a3)) : a2;
      r[103-32*c -: 8]  = mix ? (a3 ^ al ^ gmul2(a3 ^ a0)) : a3;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/aes_rr_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes_rr_if
// valid/ready channel carrying one 128-bit word as two halves
// ---------------------------------------------------------------------------
interface aes_rr_if;
  logic        valid;
  logic        ready;
  logic [63:0] high;
  logic [63:0] low;
  modport source (output valid, output high, output low, input ready);
  modport sink (input valid, input high, input low, output ready);
endinterface

// ===== rtl/core/aes_rr_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes_rr_stage
// one pipelined cipher round: key expansion step plus state round
// ---------------------------------------------------------------------------
module aes_rr_stage import aes_rr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] idx,
  input  logic       adv,
  input  logic       in_valid,
  input  blk_t       in_state,
  input  blk_t       in_key,
  input  ctl_t       in_ctl,
  output logic       out_valid,
  output blk_t       out_state,
  output blk_t       out_key,
  output ctl_t       out_ctl
);

  blk_t nkey;
  blk_t rnd;
  logic act;
  logic fin;

  assign nkey = key_step(in_key, int'(idx));
  // round number idx+1; rounds past the count pass the state through
  assign act  = ({1'b0, idx} < {1'b0, in_ctl.nrounds});
  assign fin  = (idx + 4'd1 == in_ctl.nrounds);
  assign rnd  = sub_shift_mix(in_state, !fin || in_ctl.last_mix) ^ nkey;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_state <= act ? rnd : in_state;
      out_key   <= nkey;
      out_ctl   <= in_ctl;
    end
  end

endmodule

// ===== rtl/core/aes128_reduced_round_encrypt_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes128_reduced_round_encrypt_top
// reduced-round aes-128 encryption, one round per pipeline stage
// ---------------------------------------------------------------------------
// usage:
//   words enter on blk_in (valid/ready), ciphertext leaves on blk_out.
//   apb port: 0x00 key_high, 0x08 key_low, 0x10 round_count (1..10,
//   0 acts as 1, above 10 as 10), 0x18 last_round_mixes.
//   pipeline: one key-add stage and ten round stages, eleven registers in
//   all; a word passes the key-add register, then each round stage in order.
//   throughput: one word per cycle unless the output stalls; each round stage
//   holds one s-box layer, mixcolumns and the key expansion step for that round.
//   the whole pipe advances when the output register is empty or taken;
//   a stall freezes every stage, nothing is lost or repeated.
//   reset clears all valid bits and loads key 0, round_count 10,
//   last_round_mixes 0.
//   settings are sampled at entry, so write them only while idle.
// ---------------------------------------------------------------------------
module aes128_reduced_round_encrypt_top import aes_rr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  aes_rr_if.sink       blk_in,
  aes_rr_if.source     blk_out,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [3:0]  round_count;
  logic        last_round_mixes;
  logic        wr;
  logic [3:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = {2'b00, paddr[4:3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high         <= '0;
      key_low          <= '0;
      round_count      <= 4'd10;
      last_round_mixes <= 1'b0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (reg_idx)
        RegKeyHigh: key_high         <= pwdata;
        RegKeyLow:  key_low          <= pwdata;
        RegRounds:  round_count      <= pwdata[3:0];
        RegLastMix: last_round_mixes <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyHigh: prdata = key_high;
      RegKeyLow:  prdata = key_low;
      RegRounds:  prdata = {60'd0, round_count};
      RegLastMix: prdata = {63'd0, last_round_mixes};
      default:    prdata = '0;
    endcase
  end

  logic adv;
  ctl_t ctl_in;
  blk_t key0;

  assign adv          = !blk_out.valid || blk_out.ready;
  assign blk_in.ready = adv;
  assign key0         = {key_high, key_low};

  always_comb begin
    ctl_in.last_mix = last_round_mixes;
    if (round_count == 4'd0) begin
      ctl_in.nrounds = 4'd1;
    end else if (round_count > 4'd10) begin
      ctl_in.nrounds = 4'd10;
    end else begin
      ctl_in.nrounds = round_count;
    end
  end

  logic v   [Rounds+1];
  blk_t st  [Rounds+1];
  blk_t ky  [Rounds+1];
  ctl_t cl  [Rounds+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= blk_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= {blk_in.high, blk_in.low} ^ key0;
      ky[0] <= key0;
      cl[0] <= ctl_in;
    end
  end

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    aes_rr_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .idx       (4'(g)),
      .adv       (adv),
      .in_valid  (v[g]),
      .in_state  (st[g]),
      .in_key    (ky[g]),
      .in_ctl    (cl[g]),
      .out_valid (v[g+1]),
      .out_state (st[g+1]),
      .out_key   (ky[g+1]),
      .out_ctl   (cl[g+1])
    );
  end

  assign blk_out.valid = v[Rounds];
  assign blk_out.high  = st[Rounds][127:64];
  assign blk_out.low   = st[Rounds][63:0];

  // a stalled output word holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    blk_out.valid && !blk_out.ready |=> blk_out.valid && $stable(blk_out.high)
      && $stable(blk_out.low))
    else $error("output word changed under stall");

  a_noacc: assert property (@(posedge clk) disable iff (rst)
    !adv |-> !blk_in.ready)
    else $error("input accepted while pipe frozen");

  a_first: assert property (@(posedge clk) disable iff (rst)
    adv && blk_in.valid |=> v[0])
    else $error("accepted word not captured");

  a_range: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> cl[0].nrounds != 4'd0 && cl[0].nrounds <= 4'd10)
    else $error("round count out of range");

endmodule

// ===== bench/aes128_rr_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aes128_rr_checker
// watches both word channels and the apb port, predicts the reduced-round
// ciphertext of each accepted plaintext word and compares it in order
// ---------------------------------------------------------------------------
module aes128_rr_checker import aes_rr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_high,
  input  logic [63:0] in_low,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_high,
  input  logic [63:0] out_low,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending_words,
  output int          checked_words
);

  localparam logic [7:0] SUB_TABLE [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  localparam logic [7:0] ROUND_CONST [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1B,8'h36
  };

  logic [63:0]  cfg_key_high;
  logic [63:0]  cfg_key_low;
  logic [3:0]   cfg_rounds;
  logic         cfg_last_mix;
  logic [127:0] cipher_queue [$];

  function automatic logic [7:0] xtime(logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [127:0] encrypt_word(logic [127:0] plain);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tt [16];
    logic [7:0] k12, k13, k14, k15, a0, a1, a2, a3, al;
    logic [127:0] keyw;
    logic [127:0] res;
    int n;
    keyw = {cfg_key_high, cfg_key_low};
    n = cfg_rounds;
    if (n == 0) n = 1;
    if (n > 10) n = 10;
    for (int i = 0; i < 16; i++) begin
      rk[i] = keyw[127-8*i -: 8];
      st[i] = plain[127-8*i -: 8] ^ rk[i];
    end
    for (int r = 1; r <= n; r++) begin
      k12 = rk[12]; k13 = rk[13]; k14 = rk[14]; k15 = rk[15];
      rk[0] = rk[0] ^ SUB_TABLE[k13] ^ ROUND_CONST[r-1];
      rk[1] = rk[1] ^ SUB_TABLE[k14];
      rk[2] = rk[2] ^ SUB_TABLE[k15];
      rk[3] = rk[3] ^ SUB_TABLE[k12];
      for (int w = 4; w < 16; w++) rk[w] = rk[w] ^ rk[w-4];
      for (int c = 0; c < 4; c++)
        for (int q = 0; q < 4; q++) tt[4*c+q] = SUB_TABLE[st[4*((c+q)%4)+q]];
      if (r < n || cfg_last_mix) begin
        for (int c = 0; c < 16; c += 4) begin
          a0 = tt[c]; a1 = tt[c+1]; a2 = tt[c+2]; a3 = tt[c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          tt[c]   = a0 ^ al ^ xtime(a0 ^ a1);
          tt[c+1] = a1 ^ al ^ xtime(a1 ^ a2);
          tt[c+2] = a2 ^ al ^ xtime(a2 ^ a3);
          tt[c+3] = a3 ^ al ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    checked_words = 0;
  end

  assign pending_words = cipher_queue.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst) begin
      cfg_key_high <= '0;
      cfg_key_low  <= '0;
      cfg_rounds   <= 4'd10;
      cfg_last_mix <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (cipher_queue.size() == 0) begin
          $display("unexpected word %h_%h at %0t", out_high, out_low, $realtime);
          fail_count++;
        end else begin
          want = cipher_queue.pop_front();
          if (out_high !== want[127:64]) report_mismatch("cipher_high", out_high, want[127:64]);
          if (out_low !== want[63:0]) report_mismatch("cipher_low", out_low, want[63:0]);
          checked_words++;
        end
      end
      if (in_valid && in_ready) cipher_queue.push_back(encrypt_word({in_high, in_low}));
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          RegKeyHigh[1:0]: cfg_key_high <= pwdata;
          RegKeyLow[1:0]:  cfg_key_low  <= pwdata;
          RegRounds[1:0]:  cfg_rounds   <= pwdata[3:0];
          RegLastMix[1:0]: cfg_last_mix <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== bench/tb_aes128_reduced_round_encrypt_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aes128_reduced_round_encrypt_top
// drives plaintext words and register settings into the cipher pipeline
// with random gaps and stalls; the checker predicts and compares ciphertext
// ---------------------------------------------------------------------------
module tb_aes128_reduced_round_encrypt_top import aes_rr_pkg::*; ();

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending_words;
  int          checked_words;
  int          cycle_count;
  int          long_hold;
  int          sent_words;

  aes_rr_if plain_ch ();
  aes_rr_if cipher_ch ();

  aes128_reduced_round_encrypt_top DUT (
    .clk(clk), .rst(rst), .blk_in(plain_ch.sink), .blk_out(cipher_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  aes128_rr_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(plain_ch.valid), .in_ready(plain_ch.ready),
    .in_high(plain_ch.high), .in_low(plain_ch.low),
    .out_valid(cipher_ch.valid), .out_ready(cipher_ch.ready),
    .out_high(cipher_ch.high), .out_low(cipher_ch.low),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending_words(pending_words),
    .checked_words(checked_words)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic reg_write(logic [3:0] idx, logic [63:0] value);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx[1:0], 3'b000}; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // lower valid, wait for all words out, then wait on with the pipe empty
  task automatic drain_pipe();
    @(negedge clk);
    plain_ch.valid = 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (15) @(posedge clk);
  endtask

  // valid stays high after an accept so the next word can follow at once
  task automatic send_word(logic [63:0] hi, logic [63:0] lo, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    @(negedge clk);
    if (g != 0) begin
      plain_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    plain_ch.valid = 1'b1;
    plain_ch.high = hi;
    plain_ch.low = lo;
    @(posedge clk);
    while (!plain_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  task automatic set_config(logic [63:0] kh, logic [63:0] kl, logic [3:0] nr, logic lm);
    reg_write(RegKeyHigh, kh);
    reg_write(RegKeyLow, kl);
    reg_write(RegRounds, {60'd0, nr});
    reg_write(RegLastMix, {63'd0, lm});
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_word(rand64(), rand64(), $urandom_range(0, 3) == 0);
  endtask

  // receiver: random stalls, plus one long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      cipher_ch.ready <= 1'b0;
    end else if (long_hold > 0) begin
      cipher_ch.ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else begin
      cipher_ch.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("aes128_reduced_round_encrypt_top test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] ones;
    ones = '1;
    rst = 1'b1; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0;
    plain_ch.valid = 1'b0; plain_ch.high = '0; plain_ch.low = '0;
    cycle_count = 0; long_hold = 0; sent_words = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: zero key, ten rounds, no final mix
    send_word('0, '0, 1'b0);
    send_word(ones, ones, 1'b0);
    send_word(64'h00112233_44556677, 64'h8899AABB_CCDDEEFF, 1'b0);
    drain_pipe();

    // standard aes-128 with a full final mix off
    set_config(64'h00010203_04050607, 64'h08090A0B_0C0D0E0F, 4'd10, 1'b0);
    send_word(64'h00112233_44556677, 64'h8899AABB_CCDDEEFF, 1'b0);
    send_word(ones, '0, 1'b1);
    send_word('0, ones, 1'b1);
    drain_pipe();

    // round count zero acts as one; above ten saturates
    set_config(ones, ones, 4'd0, 1'b1);
    send_word(64'h01234567_89ABCDEF, 64'hFEDCBA98_76543210, 1'b0);
    send_word(ones, ones, 1'b0);
    drain_pipe();
    set_config(ones, '0, 4'd15, 1'b1);
    send_word('0, '0, 1'b0);
    send_word(64'h80000000_00000001, 64'h00000001_80000000, 1'b0);
    drain_pipe();
    set_config('0, ones, 4'd11, 1'b0);
    send_word(ones, '0, 1'b0);
    drain_pipe();
    set_config(rand64(), rand64(), 4'd1, 1'b0);
    send_word(rand64(), rand64(), 1'b0);
    send_word(rand64(), rand64(), 1'b0);
    drain_pipe();

    // long receiver hold-off while the sender keeps offering words
    long_hold = 60;
    random_phase(40);
    drain_pipe();

    // random phases across settings; the sender pauses between each
    for (int p = 0; p < 24; p++) begin
      set_config(rand64(), rand64(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      random_phase(50);
      drain_pipe();
    end

    $display("sent %0d words across reset, extreme and random settings, checked %0d",
             sent_words, checked_words);
    $display("round counts 0..15 with and without the final mix, long output stall");
    if (fail_count == 0 && pending_words == 0) begin
      $display("aes128_reduced_round_encrypt_top test passed");
    end else begin
      $display("aes128_reduced_round_encrypt_top test failed");
    end
    $finish;
  end

endmodule
